### hw/rtl/mfbd_pkg.sv
// Shared constants and control types for the mask-fill block decompressor.
// No dependencies; used by the interfaces, controller, datapath and top level.
package mfbd_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned BLK_CNT_W       = 11;
  localparam int unsigned POS_W           = 3;
  localparam int unsigned MASKS_PER_BLOCK = 4;

  // controller -> datapath
  typedef struct packed {
    logic start;      // first word of a stream
    logic load_fill;  // fill word of a later block
    logic load_mask;  // mask word
    logic load_lit;   // literal word
    logic emit;       // write one decoded word to the output register
  } mfbd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cfg_zero;     // block count register is zero
    logic mask_lsb;     // bit 0 of the incoming word
    logic slot_free;    // output register can take a word this cycle
    logic emit_last;    // word at the current position ends the run
    logic mask_end;     // current position is the top mask bit
    logic block_end;    // current mask is the last of its block
    logic stream_last;  // current block is the last of the stream
  } mfbd_status_t;

endpackage

### hw/rtl/mfbd_in_if.sv
// Compressed input channel: one stream word and its first-of-stream mark.
// Depends on mfbd_pkg.
interface mfbd_in_if;
  logic                             valid;
  logic                             ready;
  logic [mfbd_pkg::BYTE_W-1:0]      in_byte;
  logic                             first;

  modport source (output valid, output in_byte, output first, input ready);
  modport sink   (input valid, input in_byte, input first, output ready);
endinterface

### hw/rtl/mfbd_out_if.sv
// Decoded output channel: one decoded word with run-end and stream-end marks.
// Depends on mfbd_pkg.
interface mfbd_out_if;
  logic                             valid;
  logic                             ready;
  logic [mfbd_pkg::BYTE_W-1:0]      out_byte;
  logic                             run_last;
  logic                             stream_end;

  modport source (output valid, output out_byte, output run_last, output stream_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input stream_end,
                  output ready);
endinterface

### hw/rtl/mfbd_cfg_if.sv
// Configuration write channel carrying the block count register.
// Depends on mfbd_pkg.
interface mfbd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mfbd_pkg::BLK_CNT_W-1:0]   block_count;

  modport source (output valid, output block_count, input ready);
  modport sink   (input valid, input block_count, output ready);
endinterface

### hw/rtl/mfbd_datapath.sv
// Datapath: block count register, decode state, mask position and output register.
// Depends on mfbd_pkg; driven by mfbd_ctrl through mfbd_cmd_t.
module mfbd_datapath #(
  parameter int unsigned MASKS_PER_BLOCK = mfbd_pkg::MASKS_PER_BLOCK
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [mfbd_pkg::BYTE_W-1:0]       in_byte_i,
  input  logic                              cfg_valid_i,
  input  logic [mfbd_pkg::BLK_CNT_W-1:0]    cfg_data_i,
  input  mfbd_pkg::mfbd_cmd_t               cmd_i,
  input  logic                              out_ready_i,
  output mfbd_pkg::mfbd_status_t            status_o,
  output logic                              out_valid_o,
  output logic [mfbd_pkg::BYTE_W-1:0]       out_byte_o,
  output logic                              run_last_o,
  output logic                              stream_end_o
);

  localparam int unsigned MdW = (MASKS_PER_BLOCK > 1) ? $clog2(MASKS_PER_BLOCK) : 1;
  localparam logic [MdW-1:0] MdLast = MdW'(MASKS_PER_BLOCK - 1);

  logic [mfbd_pkg::BLK_CNT_W-1:0] block_count_q;
  logic [mfbd_pkg::BLK_CNT_W-1:0] blocks_left_q, blocks_left_d;
  logic [MdW-1:0]                 masks_done_q, masks_done_d;
  logic [mfbd_pkg::POS_W-1:0]     pos_q, pos_d, pos_nx;
  logic                           lit_sel_q, lit_sel_d;
  logic                           out_valid_q, out_valid_d;
  logic [mfbd_pkg::BYTE_W-1:0]    fill_q, mask_q, lit_q;
  logic [mfbd_pkg::BYTE_W-1:0]    out_byte_q;
  logic                           run_last_q, stream_end_q;

  logic emit_last, mask_end, block_end, stream_last, slot_free;

  assign pos_nx      = pos_q + 1'b1;
  assign mask_end    = (pos_q == '1);
  // the run closes at the top mask bit, or where the next word belongs to a literal
  assign emit_last   = mask_end || mask_q[pos_nx];
  assign block_end   = (masks_done_q == MdLast);
  assign stream_last = (blocks_left_q == mfbd_pkg::BLK_CNT_W'(1));
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    status_o.cfg_zero    = (block_count_q == '0);
    status_o.mask_lsb    = in_byte_i[0];
    status_o.slot_free   = slot_free;
    status_o.emit_last   = emit_last;
    status_o.mask_end    = mask_end;
    status_o.block_end   = block_end;
    status_o.stream_last = stream_last;
  end

  always_comb begin
    blocks_left_d = blocks_left_q;
    masks_done_d  = masks_done_q;
    pos_d         = pos_q;
    lit_sel_d     = lit_sel_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    if (cmd_i.start) begin
      blocks_left_d = block_count_q;
      masks_done_d  = '0;
      pos_d         = '0;
    end
    if (cmd_i.load_fill) begin
      masks_done_d = '0;
    end
    if (cmd_i.load_mask) begin
      pos_d     = '0;
      lit_sel_d = 1'b0;
    end
    if (cmd_i.load_lit) begin
      lit_sel_d = 1'b1;
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      lit_sel_d   = 1'b0;
      pos_d       = pos_nx;
      if (mask_end) begin
        if (block_end) begin
          masks_done_d  = '0;
          blocks_left_d = blocks_left_q - 1'b1;
        end else begin
          masks_done_d = masks_done_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= '0;
      blocks_left_q <= '0;
      masks_done_q  <= '0;
      pos_q         <= '0;
      lit_sel_q     <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        block_count_q <= cfg_data_i;
      end
      blocks_left_q <= blocks_left_d;
      masks_done_q  <= masks_done_d;
      pos_q         <= pos_d;
      lit_sel_q     <= lit_sel_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start || cmd_i.load_fill) begin
      fill_q <= in_byte_i;
    end
    if (cmd_i.start) begin
      mask_q <= '0;
    end
    if (cmd_i.load_mask) begin
      mask_q <= in_byte_i;
    end
    if (cmd_i.load_lit) begin
      lit_q <= in_byte_i;
    end
    if (cmd_i.emit) begin
      out_byte_q   <= lit_sel_q ? lit_q : fill_q;
      run_last_q   <= emit_last;
      stream_end_q <= emit_last && mask_end && block_end && stream_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign run_last_o   = run_last_q;
  assign stream_end_o = stream_end_q;

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> slot_free)
    else $error("emit into an occupied output register");

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && stream_end_q) |-> run_last_q)
    else $error("stream end without run end");

endmodule

### hw/rtl/mfbd_ctrl.sv
// Controller: stream phase FSM; emit sequencer, one word per cycle unless stalled.
// Depends on mfbd_pkg; commands mfbd_datapath.
module mfbd_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      first_i,
  output logic                      in_ready_o,
  input  mfbd_pkg::mfbd_status_t    status_i,
  output mfbd_pkg::mfbd_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    S_DONE,
    S_FILL,
    S_MASK,
    S_LIT,
    S_EMIT
  } state_e;

  state_e state_q, state_d;
  logic   in_acc;

  assign in_ready_o = (state_q != S_EMIT);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    if (in_acc) begin
      if (first_i) begin
        cmd_o.start = 1'b1;
        state_d     = status_i.cfg_zero ? S_DONE : S_MASK;
      end else begin
        case (state_q)
          S_FILL: begin
            cmd_o.load_fill = 1'b1;
            state_d         = S_MASK;
          end
          S_MASK: begin
            cmd_o.load_mask = 1'b1;
            // a mask opening with a literal gives nothing yet
            state_d         = status_i.mask_lsb ? S_LIT : S_EMIT;
          end
          S_LIT: begin
            cmd_o.load_lit = 1'b1;
            state_d        = S_EMIT;
          end
          default: begin
            state_d = state_q;
          end
        endcase
      end
    end
    if (state_q == S_EMIT && status_i.slot_free) begin
      cmd_o.emit = 1'b1;
      if (status_i.emit_last) begin
        if (!status_i.mask_end) begin
          state_d = S_LIT;
        end else if (!status_i.block_end) begin
          state_d = S_MASK;
        end else begin
          state_d = status_i.stream_last ? S_DONE : S_FILL;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_DONE;
    end else begin
      state_q <= state_d;
    end
  end

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.start, cmd_o.load_fill, cmd_o.load_mask, cmd_o.load_lit, cmd_o.emit}))
    else $error("more than one datapath command");

  a_lit_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !first_i && state_q == S_LIT) |=> (state_q == S_EMIT))
    else $error("literal word not emitted");

endmodule

### hw/rtl/mask_fill_block_decompressor_top.sv
// Mask-fill block decompressor: an accepted word yields 0 to 8 decoded words.
// A literal word, or a mask word opening with a fill, moves the controller to its
// emit state: the sequencer writes one word a cycle into the single output register
// while it is free, and no input word is accepted until the run's last word is written.
// Reset: phase done awaiting a first word, block count 0, output register empty.
module mask_fill_block_decompressor_top #(
  parameter int unsigned MASKS_PER_BLOCK = mfbd_pkg::MASKS_PER_BLOCK
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  mfbd_in_if.sink         in_ch,
  mfbd_out_if.source      out_ch,
  mfbd_cfg_if.sink        cfg_ch
);

  mfbd_pkg::mfbd_cmd_t    cmd;
  mfbd_pkg::mfbd_status_t status;

  assign cfg_ch.ready = 1'b1;

  mfbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .first_i    (in_ch.first),
    .in_ready_o (in_ch.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mfbd_datapath #(
    .MASKS_PER_BLOCK (MASKS_PER_BLOCK)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_byte_i    (in_ch.in_byte),
    .cfg_valid_i  (cfg_ch.valid),
    .cfg_data_i   (cfg_ch.block_count),
    .cmd_i        (cmd),
    .out_ready_i  (out_ch.ready),
    .status_o     (status),
    .out_valid_o  (out_ch.valid),
    .out_byte_o   (out_ch.out_byte),
    .run_last_o   (out_ch.run_last),
    .stream_end_o (out_ch.stream_end)
  );

endmodule
